// ===== hdl/tqpa_pkg.sv =====
package tqpa_pkg;

	localparam int MODE_W = 2;
	localparam int SLOT_W = 4;
	localparam int ID_W   = 64;
	localparam int TYPE_W = 2;
	localparam int ST_W   = 2;

	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BYID  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_FREE  = 2'd3;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
	localparam logic [ST_W-1:0] ST_MISUSE  = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   queue_id;
		logic [TYPE_W-1:0] queue_type;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [SLOT_W-1:0] granted_slot;
		logic [ID_W-1:0]   granted_id;
		logic [TYPE_W-1:0] granted_type;
	} rsp_t;

	// write strobes from the sequencer to the two memories
	typedef struct packed {
		logic data_we;
		logic link_we;
	} mem_ctl_t;

	function automatic rsp_t fail_rsp(logic [ST_W-1:0] st);
		rsp_t r;
		r = '0;
		r.status = st;
		return r;
	endfunction

endpackage

// ===== hdl/tqpa_stream_if.sv =====
interface tqpa_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/tqpa_ram.sv =====
module tqpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/tqpa_seq.sv =====
module tqpa_seq #(
	parameter int NUM_SLOTS   = 16,
	parameter int NUM_CLASSES = 4,
	localparam int AW = $clog2(NUM_SLOTS),
	localparam int SW = $clog2(NUM_SLOTS + 1),
	localparam int LW = 2 * SW,
	localparam int DW = tqpa_pkg::ID_W + tqpa_pkg::TYPE_W
) (
	input  logic                clk,
	input  logic                arst_n,
	tqpa_stream_if.sink         req,
	output tqpa_pkg::mem_ctl_t  mem_ctl,
	output logic [AW-1:0]       data_waddr,
	output logic [DW-1:0]       data_wdata,
	output logic [AW-1:0]       data_raddr,
	input  logic [DW-1:0]       data_rdata,
	output logic [AW-1:0]       link_waddr,
	output logic [LW-1:0]       link_wdata,
	output logic [AW-1:0]       link_raddr,
	input  logic [LW-1:0]       link_rdata,
	output logic                res_valid,
	output tqpa_pkg::rsp_t      res_data,
	input  logic                res_ready
);

	localparam int HW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam logic [SW-1:0] NULL_LINK = SW'(NUM_SLOTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH_RD,
		S_PUSH_FIX,
		S_WALK,
		S_UNL_F,
		S_UNL_B,
		S_DONE
	} state_t;

	state_t                 state_q, state_d;
	logic [SW-1:0]          head_q [NUM_CLASSES];
	logic [SW-1:0]          head_d [NUM_CLASSES];
	logic [NUM_SLOTS-1:0]   held_q, held_d;
	logic [NUM_SLOTS-1:0]   listed_q, listed_d;
	tqpa_pkg::rsp_t         res_q, res_d;
	logic [SW-1:0]          cur_q, cur_d;
	logic [SW-1:0]          lnk_f_q, lnk_f_d;
	logic [SW-1:0]          lnk_b_q, lnk_b_d;
	logic [SW-1:0]          cnt_q, cnt_d;

	logic [tqpa_pkg::MODE_W-1:0] mode_q;
	logic [tqpa_pkg::SLOT_W-1:0] slot_q;
	logic [tqpa_pkg::ID_W-1:0]   id_q;
	logic [tqpa_pkg::TYPE_W-1:0] cls_q;

	logic [AW-1:0]               s_in, s_cap;
	logic [HW-1:0]               c_in, c_cap, c_rd;
	logic                        slot_ok_in, cls_ok_in;
	logic [tqpa_pkg::TYPE_W-1:0] cls_rd;
	logic [tqpa_pkg::ID_W-1:0]   id_rd;
	logic [SW-1:0]               h_rd, fwd_rd, bwd_rd;
	logic                        hit;

	assign req.ready  = (state_q == S_IDLE);
	assign s_in       = AW'(req.data.slot);
	assign c_in       = HW'(req.data.queue_type);
	assign slot_ok_in = 32'(req.data.slot) < NUM_SLOTS;
	assign cls_ok_in  = 32'(req.data.queue_type) < NUM_CLASSES;
	assign s_cap      = AW'(slot_q);
	assign c_cap      = HW'(cls_q);
	assign cls_rd     = data_rdata[tqpa_pkg::TYPE_W-1:0];
	assign id_rd      = data_rdata[DW-1:tqpa_pkg::TYPE_W];
	assign c_rd       = HW'(cls_rd);
	assign h_rd       = head_q[c_rd];
	assign fwd_rd     = link_rdata[LW-1:SW];
	assign bwd_rd     = link_rdata[SW-1:0];
	assign hit        = (mode_q == tqpa_pkg::MODE_FIRST) || (id_rd == id_q);
	assign res_data   = res_q;

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		held_d     = held_q;
		listed_d   = listed_q;
		res_d      = res_q;
		cur_d      = cur_q;
		lnk_f_d    = lnk_f_q;
		lnk_b_d    = lnk_b_q;
		cnt_d      = cnt_q;
		mem_ctl    = '0;
		data_waddr = '0;
		data_wdata = '0;
		data_raddr = '0;
		link_waddr = '0;
		link_wdata = '0;
		link_raddr = '0;
		res_valid  = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					unique case (req.data.mode) inside
						tqpa_pkg::MODE_ADD: begin
							if (!cls_ok_in || !slot_ok_in || held_q[s_in] || listed_q[s_in]) begin
								res_d   = tqpa_pkg::fail_rsp(tqpa_pkg::ST_MISUSE);
								state_d = S_DONE;
							end else begin
								mem_ctl.data_we = 1'b1;
								data_waddr      = s_in;
								data_wdata      = {req.data.queue_id, req.data.queue_type};
								mem_ctl.link_we = 1'b1;
								link_waddr      = s_in;
								link_wdata      = {head_q[c_in], NULL_LINK};
								link_raddr      = head_q[c_in][AW-1:0];
								head_d[c_in]    = SW'(s_in);
								listed_d[s_in]  = 1'b1;
								res_d.status       = tqpa_pkg::ST_OK;
								res_d.granted_slot = req.data.slot;
								res_d.granted_id   = req.data.queue_id;
								res_d.granted_type = req.data.queue_type;
								cur_d   = head_q[c_in];
								state_d = (head_q[c_in] != NULL_LINK) ? S_PUSH_FIX : S_DONE;
							end
						end
						tqpa_pkg::MODE_FREE: begin
							if (!slot_ok_in || !held_q[s_in]) begin
								res_d   = tqpa_pkg::fail_rsp(tqpa_pkg::ST_MISUSE);
								state_d = S_DONE;
							end else begin
								data_raddr = s_in;
								state_d    = S_PUSH_RD;
							end
						end
						tqpa_pkg::MODE_FIRST, tqpa_pkg::MODE_BYID: begin
							if (!cls_ok_in) begin
								res_d   = tqpa_pkg::fail_rsp(tqpa_pkg::ST_MISUSE);
								state_d = S_DONE;
							end else if (head_q[c_in] == NULL_LINK) begin
								res_d   = tqpa_pkg::fail_rsp(tqpa_pkg::ST_MISSING);
								state_d = S_DONE;
							end else begin
								data_raddr = head_q[c_in][AW-1:0];
								link_raddr = head_q[c_in][AW-1:0];
								cur_d      = head_q[c_in];
								cnt_d      = '0;
								state_d    = S_WALK;
							end
						end
					endcase
				end
			end

			// stored class of the freed slot is now on the data read port
			S_PUSH_RD: begin
				if (32'(cls_rd) >= NUM_CLASSES) begin
					res_d   = tqpa_pkg::fail_rsp(tqpa_pkg::ST_MISUSE);
					state_d = S_DONE;
				end else begin
					mem_ctl.link_we = 1'b1;
					link_waddr      = s_cap;
					link_wdata      = {h_rd, NULL_LINK};
					link_raddr      = h_rd[AW-1:0];
					head_d[c_rd]    = SW'(s_cap);
					listed_d[s_cap] = 1'b1;
					held_d[s_cap]   = 1'b0;
					res_d.status       = tqpa_pkg::ST_OK;
					res_d.granted_slot = slot_q;
					res_d.granted_id   = id_rd;
					res_d.granted_type = cls_rd;
					cur_d   = h_rd;
					state_d = (h_rd != NULL_LINK) ? S_PUSH_FIX : S_DONE;
				end
			end

			// old head gets the new slot as its backward neighbor
			S_PUSH_FIX: begin
				mem_ctl.link_we = 1'b1;
				link_waddr      = cur_q[AW-1:0];
				link_wdata      = {fwd_rd, SW'(s_cap)};
				state_d         = S_DONE;
			end

			S_WALK: begin
				if (hit) begin
					held_d[cur_q[AW-1:0]]   = 1'b1;
					listed_d[cur_q[AW-1:0]] = 1'b0;
					if (head_q[c_cap] == cur_q) begin
						head_d[c_cap] = fwd_rd;
					end
					res_d.status       = tqpa_pkg::ST_OK;
					res_d.granted_slot = tqpa_pkg::SLOT_W'(cur_q);
					res_d.granted_id   = id_rd;
					res_d.granted_type = cls_rd;
					lnk_f_d = fwd_rd;
					lnk_b_d = bwd_rd;
					if (fwd_rd != NULL_LINK) begin
						link_raddr = fwd_rd[AW-1:0];
						state_d    = S_UNL_F;
					end else if (bwd_rd != NULL_LINK) begin
						link_raddr = bwd_rd[AW-1:0];
						state_d    = S_UNL_B;
					end else begin
						state_d = S_DONE;
					end
				end else begin
					cnt_d = cnt_q + SW'(1);
					if (fwd_rd == NULL_LINK || cnt_q + SW'(1) == SW'(NUM_SLOTS)) begin
						res_d   = tqpa_pkg::fail_rsp(tqpa_pkg::ST_MISSING);
						state_d = S_DONE;
					end else begin
						data_raddr = fwd_rd[AW-1:0];
						link_raddr = fwd_rd[AW-1:0];
						cur_d      = fwd_rd;
					end
				end
			end

			S_UNL_F: begin
				mem_ctl.link_we = 1'b1;
				link_waddr      = lnk_f_q[AW-1:0];
				link_wdata      = {fwd_rd, lnk_b_q};
				if (lnk_b_q != NULL_LINK) begin
					link_raddr = lnk_b_q[AW-1:0];
					state_d    = S_UNL_B;
				end else begin
					state_d = S_DONE;
				end
			end

			S_UNL_B: begin
				mem_ctl.link_we = 1'b1;
				link_waddr      = lnk_b_q[AW-1:0];
				link_wdata      = {lnk_f_q, bwd_rd};
				state_d         = S_DONE;
			end

			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				head_q[i] <= NULL_LINK;
			end
			held_q   <= '0;
			listed_q <= '0;
			res_q    <= '0;
			cur_q    <= '0;
			lnk_f_q  <= '0;
			lnk_b_q  <= '0;
			cnt_q    <= '0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			held_q   <= held_d;
			listed_q <= listed_d;
			res_q    <= res_d;
			cur_q    <= cur_d;
			lnk_f_q  <= lnk_f_d;
			lnk_b_q  <= lnk_b_d;
			cnt_q    <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_q <= req.data.mode;
			slot_q <= req.data.slot;
			id_q   <= req.data.queue_id;
			cls_q  <= req.data.queue_type;
		end
	end

endmodule

// ===== hdl/typed_queue_pool_allocator_core.sv =====
// One request at a time: the sequencer takes a new request only when idle, and every response
// passes through the output register. Allocate-first and allocate-by-id walk the class list
// from its head, one entry per step; a miss ends at the end of the list, and misuse and empty
// class replies carry only a status, with all other fields zero.
// Reset clears class heads and held/listed flags at once; no clearing pass is needed, and
// identifier, class and link memories are left undefined until written.
module typed_queue_pool_allocator_core #(
	parameter int NUM_SLOTS   = 16,
	parameter int NUM_CLASSES = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	tqpa_stream_if.sink   req,
	tqpa_stream_if.source rsp
);

	localparam int AW = $clog2(NUM_SLOTS);
	localparam int SW = $clog2(NUM_SLOTS + 1);
	localparam int LW = 2 * SW;
	localparam int DW = tqpa_pkg::ID_W + tqpa_pkg::TYPE_W;

	tqpa_pkg::mem_ctl_t mem_ctl;
	logic [AW-1:0]      data_waddr, data_raddr, link_waddr, link_raddr;
	logic [DW-1:0]      data_wdata, data_rdata;
	logic [LW-1:0]      link_wdata, link_rdata;
	logic               res_valid, res_ready;
	tqpa_pkg::rsp_t     res_data;
	logic               out_valid_q;
	tqpa_pkg::rsp_t     out_data_q;

	tqpa_ram #(
		.WIDTH(DW),
		.DEPTH(NUM_SLOTS)
	) u_data_ram (
		.clk  (clk),
		.we   (mem_ctl.data_we),
		.waddr(data_waddr),
		.wdata(data_wdata),
		.raddr(data_raddr),
		.rdata(data_rdata)
	);

	tqpa_ram #(
		.WIDTH(LW),
		.DEPTH(NUM_SLOTS)
	) u_link_ram (
		.clk  (clk),
		.we   (mem_ctl.link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.raddr(link_raddr),
		.rdata(link_rdata)
	);

	tqpa_seq #(
		.NUM_SLOTS  (NUM_SLOTS),
		.NUM_CLASSES(NUM_CLASSES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mem_ctl   (mem_ctl),
		.data_waddr(data_waddr),
		.data_wdata(data_wdata),
		.data_raddr(data_raddr),
		.data_rdata(data_rdata),
		.link_waddr(link_waddr),
		.link_wdata(link_wdata),
		.link_raddr(link_raddr),
		.link_rdata(link_rdata),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_ready (res_ready)
	);

	// output register decouples the response side from the sequencer
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res_data;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while another is in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.data.status == tqpa_pkg::ST_OK
			|| rsp.data.status == tqpa_pkg::ST_MISSING
			|| rsp.data.status == tqpa_pkg::ST_MISUSE))
		else $error("undefined status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.status != tqpa_pkg::ST_OK) |->
			(rsp.data.granted_slot == '0 && rsp.data.granted_id == '0
			&& rsp.data.granted_type == '0))
		else $error("failed response carries nonzero fields");

endmodule
